@@ rtl/cfp_pkg.sv @@
package cfp_pkg;

    localparam logic [7:0]  MAGIC_HI    = 8'h41;
    localparam logic [7:0]  MAGIC_LO    = 8'h42;
    localparam logic [15:0] MAGIC_RESET = {MAGIC_HI, MAGIC_LO};

    localparam logic [3:0]  HDR_MAGIC_END   = 4'd2;
    localparam logic [3:0]  HDR_VERSION_END = 4'd4;
    localparam logic [3:0]  HDR_COMMAND_END = 4'd6;
    localparam logic [3:0]  HDR_LENGTH_END  = 4'd10;
    localparam logic [3:0]  HDR_LAST        = 4'd13;

    localparam logic [31:0] BODY_SEQ_END     = 32'd4;
    localparam logic [31:0] BODY_STAMP_END   = 32'd12;
    localparam logic [31:0] BODY_PAYLOAD_END = 32'd16;
    localparam logic [31:0] BODY_MIN         = 32'd16;

    localparam int RESULT_BITS = 258;
    localparam int TDATA_BITS  = 264;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_BODY   = 3'b010,
        PH_DROP   = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_BAD_MAGIC     = 2'd1,
        ST_CSUM_MISMATCH = 2'd2,
        ST_BODY_SHORT    = 2'd3
    } status_t;

    // first member lands in the highest bits
    typedef struct packed {
        logic [31:0] payload_word;
        logic [63:0] time_stamp;
        logic [31:0] sequence_number;
        logic [31:0] checksum_computed;
        logic [31:0] checksum_received;
        logic [31:0] body_length;
        logic [15:0] command;
        logic [15:0] version;
        status_t     status;
    } result_t;

endpackage

@@ rtl/checksummed_frame_parser.sv @@
// channel   | dir | tdata (low bit up)                                 | tuser
// s_        | in  | rx_byte[7:0]                                       | conn_start
// m_        | out | status, version, command, body_length,            | -
//           |     | checksum_received, checksum_computed,              |
//           |     | sequence_number, time_stamp, payload_word, 0 pad   |
// cfg_wr    | in  | magic_word[15:0]                                   | -
//
// One byte per cycle while s_tready is high; a status request is registered into the output
// register, or into the skid stage while m_ stalls, from the byte that ends the packet.
// Reset is synchronous, active low; magic_word returns to "AB".
// A one-entry skid stage behind the output register keeps s_tready high
// while m_tready stalls with one request held; it drops only while the skid is full.
module checksummed_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    input  logic        s_tuser,   // conn_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [cfp_pkg::TDATA_BITS-1:0] m_tdata  // status[1:0], version[17:2],
                                                    // command[33:18], body_length[65:34],
                                                    // checksum_received[97:66],
                                                    // checksum_computed[129:98],
                                                    // sequence_number[161:130],
                                                    // time_stamp[225:162],
                                                    // payload_word[257:226], zero pad
);

    logic [15:0]      magic_word_reg;
    cfp_pkg::phase_t  phase_reg, phase_next, phase_b;
    logic [3:0]       hidx_reg, hidx_next, hidx_b;
    logic [15:0]      magic_reg, magic_next, magic_b;
    logic [15:0]      version_reg, version_next, version_b;
    logic [15:0]      command_reg, command_next, command_b;
    logic [31:0]      length_reg, length_next, length_b;
    logic [31:0]      csum_reg, csum_next, csum_b;
    logic [31:0]      count_reg, count_next, count_b;
    logic [31:0]      sum_reg, sum_next, sum_b;
    logic [31:0]      seq_reg, seq_next, seq_b;
    logic [63:0]      stamp_reg, stamp_next, stamp_b;
    logic [31:0]      payload_reg, payload_next, payload_b;

    cfp_pkg::result_t res;
    logic             res_fire;
    cfp_pkg::result_t out_data_reg;
    logic             out_valid_reg;
    cfp_pkg::result_t skid_data_reg;
    logic             skid_valid_reg;

    logic       s_fire;
    logic [7:0] b;
    logic [31:0] body_sum;
    logic [31:0] body_cnt;

    assign s_tready = !skid_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(cfp_pkg::TDATA_BITS - cfp_pkg::RESULT_BITS){1'b0}}, out_data_reg};

    // conn_start discards the packet in progress
    assign phase_b   = s_tuser ? cfp_pkg::PH_HEADER : phase_reg;
    assign hidx_b    = s_tuser ? 4'd0  : hidx_reg;
    assign magic_b   = s_tuser ? 16'd0 : magic_reg;
    assign version_b = s_tuser ? 16'd0 : version_reg;
    assign command_b = s_tuser ? 16'd0 : command_reg;
    assign length_b  = s_tuser ? 32'd0 : length_reg;
    assign csum_b    = s_tuser ? 32'd0 : csum_reg;
    assign count_b   = s_tuser ? 32'd0 : count_reg;
    assign sum_b     = s_tuser ? 32'd0 : sum_reg;
    assign seq_b     = s_tuser ? 32'd0 : seq_reg;
    assign stamp_b   = s_tuser ? 64'd0 : stamp_reg;
    assign payload_b = s_tuser ? 32'd0 : payload_reg;

    assign body_sum    = sum_b + {24'd0, b};
    assign body_cnt    = count_b + 32'd1;

    always_comb begin
        phase_next   = phase_reg;
        hidx_next    = hidx_reg;
        magic_next   = magic_reg;
        version_next = version_reg;
        command_next = command_reg;
        length_next  = length_reg;
        csum_next    = csum_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        seq_next     = seq_reg;
        stamp_next   = stamp_reg;
        payload_next = payload_reg;
        res_fire     = 1'b0;
        res          = '0;
        if (s_fire) begin
            phase_next   = phase_b;
            hidx_next    = hidx_b;
            magic_next   = magic_b;
            version_next = version_b;
            command_next = command_b;
            length_next  = length_b;
            csum_next    = csum_b;
            count_next   = count_b;
            sum_next     = sum_b;
            seq_next     = seq_b;
            stamp_next   = stamp_b;
            payload_next = payload_b;
            case (phase_b)
                cfp_pkg::PH_HEADER: begin
                    if (hidx_b < cfp_pkg::HDR_MAGIC_END) begin
                        magic_next = {magic_b[7:0], b};
                    end else if (hidx_b < cfp_pkg::HDR_VERSION_END) begin
                        version_next = {version_b[7:0], b};
                    end else if (hidx_b < cfp_pkg::HDR_COMMAND_END) begin
                        command_next = {command_b[7:0], b};
                    end else if (hidx_b < cfp_pkg::HDR_LENGTH_END) begin
                        length_next = {length_b[23:0], b};
                    end else begin
                        csum_next = {csum_b[23:0], b};
                    end
                    hidx_next = hidx_b + 4'd1;
                    if (hidx_b == cfp_pkg::HDR_LAST) begin
                        hidx_next                = 4'd0;
                        count_next               = 32'd0;
                        sum_next                 = 32'd0;
                        res.version              = version_b;
                        res.command              = command_b;
                        res.body_length          = length_b;
                        res.checksum_received    = csum_next;
                        if (magic_b != magic_word_reg) begin
                            res_fire   = 1'b1;
                            res.status = cfp_pkg::ST_BAD_MAGIC;
                            phase_next = cfp_pkg::PH_DROP;
                        end else if (length_b == 32'd0) begin
                            res_fire   = 1'b1;
                            res.status = (csum_next != 32'd0) ? cfp_pkg::ST_CSUM_MISMATCH
                                                              : cfp_pkg::ST_BODY_SHORT;
                            phase_next = cfp_pkg::PH_DROP;
                        end else begin
                            phase_next = cfp_pkg::PH_BODY;
                        end
                    end
                end
                cfp_pkg::PH_BODY: begin
                    sum_next = body_sum;
                    if (count_b < cfp_pkg::BODY_SEQ_END) begin
                        seq_next = {seq_b[23:0], b};
                    end else if (count_b < cfp_pkg::BODY_STAMP_END) begin
                        stamp_next = {stamp_b[55:0], b};
                    end else if (count_b < cfp_pkg::BODY_PAYLOAD_END) begin
                        payload_next = {payload_b[23:0], b};
                    end
                    count_next = body_cnt;
                    if (body_cnt >= length_b) begin
                        res_fire              = 1'b1;
                        phase_next            = cfp_pkg::PH_DROP;
                        res.version           = version_b;
                        res.command           = command_b;
                        res.body_length       = length_b;
                        res.checksum_received = csum_b;
                        res.checksum_computed = body_sum;
                        if (body_sum != csum_b) begin
                            res.status = cfp_pkg::ST_CSUM_MISMATCH;
                        end else if (length_b < cfp_pkg::BODY_MIN) begin
                            res.status = cfp_pkg::ST_BODY_SHORT;
                        end else begin
                            res.status          = cfp_pkg::ST_OK;
                            res.sequence_number = seq_next;
                            res.time_stamp      = stamp_next;
                            res.payload_word    = payload_next;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_word_reg <= cfp_pkg::MAGIC_RESET;
            phase_reg      <= cfp_pkg::PH_HEADER;
            hidx_reg       <= 4'd0;
            magic_reg      <= 16'd0;
            version_reg    <= 16'd0;
            command_reg    <= 16'd0;
            length_reg     <= 32'd0;
            csum_reg       <= 32'd0;
            count_reg      <= 32'd0;
            sum_reg        <= 32'd0;
            seq_reg        <= 32'd0;
            stamp_reg      <= 64'd0;
            payload_reg    <= 32'd0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                magic_word_reg <= cfg_wr_data;
            end
            phase_reg   <= phase_next;
            hidx_reg    <= hidx_next;
            magic_reg   <= magic_next;
            version_reg <= version_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            csum_reg    <= csum_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            seq_reg     <= seq_next;
            stamp_reg   <= stamp_next;
            payload_reg <= payload_next;
            if (s_fire && res_fire) begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (out_valid_reg && m_tready) begin
                if (skid_valid_reg) begin
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && res_fire) begin
            if (!out_valid_reg || m_tready) begin
                out_data_reg <= res;
            end else begin
                skid_data_reg <= res;
            end
        end else if (out_valid_reg && m_tready && skid_valid_reg) begin
            out_data_reg <= skid_data_reg;
        end
    end

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a request while output register is empty");

    a_fail_no_body: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] != cfp_pkg::ST_OK)) |->
            (m_tdata[257:130] == 128'd0))
        else $error("failed packet carries body fields");

    a_bad_magic_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] == cfp_pkg::ST_BAD_MAGIC)) |->
            (m_tdata[129:98] == 32'd0))
        else $error("bad magic request carries a body sum");

    a_drop_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && res_fire) |=> (phase_reg == cfp_pkg::PH_DROP))
        else $error("parser not in drop phase after a result");

endmodule

@@ bench/cfp_status_check.sv @@
module cfp_status_check
    import cfp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // rx_byte[7:0]
    input  logic                  s_tuser,   // conn_start
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [TDATA_BITS-1:0] m_tdata,   // status, version, command, body_length,
                                             // checksum_received, checksum_computed,
                                             // sequence_number, time_stamp,
                                             // payload_word, zero pad
    output int                    mismatches,
    output int                    pending,
    output int                    results_checked,
    output int                    ok_results
);
    timeunit 1ns;
    timeprecision 1ps;

    phase_t      parse_phase;
    logic [3:0]  hdr_pos;
    logic [15:0] magic_word;
    logic [15:0] magic_seen;
    logic [15:0] version_q;
    logic [15:0] command_q;
    logic [31:0] length_q;
    logic [31:0] csum_q;
    logic [31:0] body_pos;
    logic [31:0] body_sum;
    logic [31:0] seq_q;
    logic [63:0] stamp_q;
    logic [31:0] payload_q;

    result_t status_q[$];
    int bad_results = 0;
    int seen = 0;
    int good = 0;

    task automatic restart_parse();
        parse_phase = PH_HEADER;
        hdr_pos     = '0;
        magic_seen  = '0;
        version_q   = '0;
        command_q   = '0;
        length_q    = '0;
        csum_q      = '0;
        body_pos    = '0;
        body_sum    = '0;
        seq_q       = '0;
        stamp_q     = '0;
        payload_q   = '0;
    endtask

    task automatic post_status(input status_t st, input bit with_sum);
        result_t r;
        r.status            = st;
        r.version           = version_q;
        r.command           = command_q;
        r.body_length       = length_q;
        r.checksum_received = csum_q;
        r.checksum_computed = with_sum ? body_sum : '0;
        r.sequence_number   = (st == ST_OK) ? seq_q : '0;
        r.time_stamp        = (st == ST_OK) ? stamp_q : '0;
        r.payload_word      = (st == ST_OK) ? payload_q : '0;
        status_q.push_back(r);
        parse_phase = PH_DROP;
    endtask

    // mismatch wins over short body
    task automatic judge_body();
        if (body_sum != csum_q) begin
            post_status(ST_CSUM_MISMATCH, 1'b1);
        end else if (length_q < BODY_MIN) begin
            post_status(ST_BODY_SHORT, 1'b1);
        end else begin
            post_status(ST_OK, 1'b1);
        end
    endtask

    task automatic take_byte(input logic [7:0] b, input logic start);
        if (start) begin
            restart_parse();
        end
        case (parse_phase)
            PH_HEADER: begin
                if (hdr_pos < HDR_MAGIC_END) begin
                    magic_seen = {magic_seen[7:0], b};
                end else if (hdr_pos < HDR_VERSION_END) begin
                    version_q = {version_q[7:0], b};
                end else if (hdr_pos < HDR_COMMAND_END) begin
                    command_q = {command_q[7:0], b};
                end else if (hdr_pos < HDR_LENGTH_END) begin
                    length_q = {length_q[23:0], b};
                end else begin
                    csum_q = {csum_q[23:0], b};
                end
                if (hdr_pos == HDR_LAST) begin
                    hdr_pos = '0;
                    if (magic_seen != magic_word) begin
                        post_status(ST_BAD_MAGIC, 1'b0);
                    end else begin
                        parse_phase = PH_BODY;
                        body_pos    = '0;
                        body_sum    = '0;
                        if (length_q == '0) begin
                            judge_body();
                        end
                    end
                end else begin
                    hdr_pos = hdr_pos + 4'd1;
                end
            end
            PH_BODY: begin
                body_sum = body_sum + 32'(b);
                if (body_pos < BODY_SEQ_END) begin
                    seq_q = {seq_q[23:0], b};
                end else if (body_pos < BODY_STAMP_END) begin
                    stamp_q = {stamp_q[55:0], b};
                end else if (body_pos < BODY_PAYLOAD_END) begin
                    payload_q = {payload_q[23:0], b};
                end
                body_pos = body_pos + 32'd1;
                if (body_pos >= length_q) begin
                    judge_body();
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic note_field(input string name, input logic [63:0] want,
                              input logic [63:0] got, inout bit bad);
        if (want !== got) begin
            if (bad_results < 10) begin
                $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            end
            bad = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        bit      bad;
        if (!aresetn) begin
            magic_word = MAGIC_RESET;
            restart_parse();
            status_q.delete();
        end else begin
            if (cfg_wr_en) begin
                magic_word = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                take_byte(s_tdata, s_tuser);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[RESULT_BITS-1:0];
                bad = 1'b0;
                if (status_q.size() == 0) begin
                    if (bad_results < 10) begin
                        $display("%0t: status request with none pending: %0h",
                                 $time, m_tdata);
                    end
                    bad_results++;
                end else begin
                    want = status_q.pop_front();
                    note_field("status", 64'(want.status), 64'(got.status), bad);
                    note_field("version", 64'(want.version), 64'(got.version), bad);
                    note_field("command", 64'(want.command), 64'(got.command), bad);
                    note_field("body_length", 64'(want.body_length),
                               64'(got.body_length), bad);
                    note_field("checksum_received", 64'(want.checksum_received),
                               64'(got.checksum_received), bad);
                    note_field("checksum_computed", 64'(want.checksum_computed),
                               64'(got.checksum_computed), bad);
                    note_field("sequence_number", 64'(want.sequence_number),
                               64'(got.sequence_number), bad);
                    note_field("time_stamp", want.time_stamp, got.time_stamp, bad);
                    note_field("payload_word", 64'(want.payload_word),
                               64'(got.payload_word), bad);
                    note_field("zero pad", '0, 64'(m_tdata[TDATA_BITS-1:RESULT_BITS]), bad);
                    if (bad) begin
                        bad_results++;
                    end
                    seen++;
                    if (want.status == ST_OK) begin
                        good++;
                    end
                end
            end
        end
        mismatches      <= bad_results;
        pending         <= status_q.size();
        results_checked <= seen;
        ok_results      <= good;
    end

endmodule

@@ bench/tb_checksummed_frame_parser.sv @@
module tb_checksummed_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [15:0]           cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata     = '0;   // rx_byte[7:0]
    logic                  s_tuser     = 1'b0; // conn_start
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [cfp_pkg::TDATA_BITS-1:0] m_tdata;  // status, version, command, body_length,
                                              // checksum_received, checksum_computed,
                                              // sequence_number, time_stamp,
                                              // payload_word, zero pad

    int mismatches;
    int pending;
    int results_checked;
    int ok_results;

    logic [7:0]  frame_q[$];
    logic [15:0] cur_magic   = cfp_pkg::MAGIC_RESET;
    logic [15:0] magic_plan[4];
    int          bytes_sent  = 0;
    int          frames_sent = 0;
    int          byte_target = 0;
    int          gap_pct     = 0;
    int          stall_pct   = 0;
    int          stall_left  = 0;
    int          idle_run    = 0;
    bit          calm        = 1'b0;

    always #1 aclk = ~aclk;

    checksummed_frame_parser dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    cfp_status_check u_status_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .ok_results      (ok_results)
    );

    // result side back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(1, 11);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
        if ($urandom_range(0, 127) == 0) begin
            stall_pct <= 12 * $urandom_range(0, 2);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_run <= 0;
        end else begin
            idle_run <= idle_run + 1;
        end
        if (idle_run >= IDLE_LIMIT) begin
            $display("%0t: no traffic for %0d cycles, %0d requests outstanding",
                     $time, IDLE_LIMIT, pending);
            $display("tb_checksummed_frame_parser NOT OK");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic start);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // fill < 0: random body bytes, biased toward 00 and FF
    task automatic build_frame(input logic [15:0] mg, input logic [15:0] ver,
                               input logic [15:0] cmd, input logic [31:0] len,
                               input int nbody, input int fill, input bit good_sum);
        logic [7:0]   body[$];
        logic [7:0]   b;
        logic [31:0]  sum;
        logic [31:0]  csum;
        logic [111:0] hdr;
        int           i;
        sum = '0;
        for (i = 0; i < nbody; i++) begin
            if (fill >= 0) begin
                b = 8'(fill);
            end else begin
                case ($urandom_range(0, 9))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom);
                endcase
            end
            body.push_back(b);
            sum = sum + 32'(b);
        end
        csum = good_sum ? sum : (sum ^ ($urandom | 32'd1));
        hdr  = {mg, ver, cmd, len, csum};
        frame_q.delete();
        for (i = 0; i < 14; i++) begin
            frame_q.push_back(hdr[111 - 8 * i -: 8]);
        end
        foreach (body[k]) begin
            frame_q.push_back(body[k]);
        end
    endtask

    task automatic send_frame(input int cut, input bit with_start);
        int i;
        for (i = 0; i < frame_q.size() && i < cut; i++) begin
            push_byte(frame_q[i], with_start && i == 0);
        end
        frames_sent++;
    endtask

    task automatic random_frame(input bit may_break);
        int          kind;
        int          lsel;
        logic [31:0] len;
        gap_pct = calm ? 0 : 10 * $urandom_range(0, 3);
        kind    = may_break ? $urandom_range(0, 99) : 99;
        lsel    = $urandom_range(0, 9);
        if (lsel < 6) begin
            len = $urandom_range(16, 24);
        end else if (lsel < 8) begin
            len = $urandom_range(0, 15);
        end else if (lsel < 9) begin
            len = $urandom_range(25, 48);
        end else begin
            len = cfp_pkg::BODY_MIN;
        end
        if (kind < 10) begin
            // wrong magic, trailing bytes land in drop
            build_frame(cur_magic ^ 16'($urandom_range(1, 65535)), 16'($urandom),
                        16'($urandom), $urandom, $urandom_range(0, 3), -1, 1'b1);
            send_frame(frame_q.size(), 1'b1);
        end else if (kind < 20) begin
            // cut short by the next start
            if ($urandom_range(0, 1) == 1) begin
                len = $urandom;
            end
            build_frame(cur_magic, 16'($urandom), 16'($urandom), len,
                        (len > 48) ? 20 : int'(len), -1, 1'b1);
            send_frame($urandom_range(1, frame_q.size() - 1), 1'b1);
        end else begin
            build_frame(cur_magic, 16'($urandom), 16'($urandom), len, int'(len), -1,
                        $urandom_range(0, 9) != 0);
            send_frame(frame_q.size(), 1'b1);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
            end
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_magic(input logic [15:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_magic = v;
    endtask

    initial begin
        magic_plan[0] = 16'h0000;
        magic_plan[1] = 16'hFFFF;
        magic_plan[2] = 16'($urandom);
        magic_plan[3] = cfp_pkg::MAGIC_RESET;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // header with no start flag, zero length, matching zero sum
        build_frame(cfp_pkg::MAGIC_RESET, 16'h0001, 16'h0002, 32'd0, 0, 0, 1'b1);
        send_frame(14, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        // start lands mid header, then the full frame
        build_frame(cfp_pkg::MAGIC_RESET, 16'hFFFF, 16'h0000, 32'd16, 16, 8'hFF, 1'b1);
        send_frame(5, 1'b1);
        send_frame(frame_q.size(), 1'b1);
        // swapped magic bytes
        build_frame(16'h4241, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 2, 0, 1'b0);
        send_frame(frame_q.size(), 1'b1);
        // zero length, nonzero checksum
        build_frame(cfp_pkg::MAGIC_RESET, 16'h0000, 16'h0000, 32'd0, 0, 0, 1'b0);
        send_frame(frame_q.size(), 1'b1);
        build_frame(cfp_pkg::MAGIC_RESET, 16'h8000, 16'h0001, 32'd5, 5, -1, 1'b1);
        send_frame(frame_q.size(), 1'b1);
        build_frame(cfp_pkg::MAGIC_RESET, 16'h1234, 16'h8000, 32'd17, 17, -1, 1'b0);
        send_frame(frame_q.size(), 1'b1);
        build_frame(cfp_pkg::MAGIC_RESET, 16'h0000, 16'hFFFF, 32'd16, 16, 0, 1'b1);
        send_frame(frame_q.size(), 1'b1);

        for (int p = 0; p < 5; p++) begin
            if (p > 0) begin
                write_magic(magic_plan[p - 1]);
            end
            calm = (p == 4);
            byte_target = byte_target + 270;
            while (bytes_sent < byte_target) begin
                random_frame(1'b1);
            end
            random_frame(1'b0);
        end

        drain();
        $display("Sent %0d bytes in %0d frames under 5 magic settings, with random stalls.",
                 bytes_sent, frames_sent);
        $display("Checked %0d status requests, %0d of them good packets.",
                 results_checked, ok_results);
        if (pending != 0) begin
            $display("%0d status requests never arrived", pending);
        end
        if (mismatches == 0 && pending == 0) begin
            $display("tb_checksummed_frame_parser OK");
        end else begin
            $display("tb_checksummed_frame_parser NOT OK");
        end
        $finish;
    end

endmodule
